@@ rtl/core/mpsnh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mpsnh_pkg;

    // default table depth
    localparam int MAX_NEIGHBORS_DEF = 16;

    // parent selection constants
    localparam int        SCORE_W     = 7;
    localparam int        PEN_W       = 5;
    localparam logic [7:0] HOP_LIMIT  = 8'd8;
    localparam logic [6:0] HOP_WEIGHT = 7'd10;
    localparam logic [7:0] RSSI_KNEE  = 8'd40;
    localparam logic [7:0] ORPHAN_HOPS = 8'hFF;

    // reciprocal of five for values below 128: x/5 == (x*205) >> 10
    localparam logic [14:0] RECIP5     = 15'd205;
    localparam int          RECIP5_SHR = 10;

    // command codes
    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_COUNT  = 2'd1,
        ACT_PARENT = 2'd2,
        ACT_QUERY  = 2'd3
    } t_action;

    // record handed from cell to cell during a scan
    typedef struct packed {
        logic               found;
        logic [SCORE_W-1:0] score;
        logic [15:0]        id;
        logic [2:0]         hops;
        logic signed [7:0]  rssi;
        logic               match;
    } t_scan;

    // signal strength penalty: max(0, |rssi| - 40) / 5
    function automatic logic [PEN_W-1:0] link_penalty(input logic signed [7:0] rssi);
        logic [7:0]  mag;
        logic [6:0]  over;
        logic [14:0] prod;
        mag  = rssi[7] ? (8'(~rssi) + 8'd1) : 8'(rssi);
        over = (mag < RSSI_KNEE) ? 7'd0 : 7'(mag - RSSI_KNEE);
        prod = 15'(over) * RECIP5;
        return PEN_W'(prod >> RECIP5_SHR);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/mpsnh_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mpsnh_cell #(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 5
) (
    input  wire                  i_clk,
    input  wire                  i_wr_en,
    input  wire [15:0]           i_nb_id,
    input  wire [7:0]            i_nb_hops,
    input  wire [15:0]           i_nb_uplink,
    input  wire signed [7:0]     i_nb_rssi,
    input  wire [CNT_W-1:0]      i_count,
    input  wire [15:0]           i_own_id,
    input  wire [15:0]           i_dst,
    input  wire mpsnh_pkg::t_scan i_scan,
    output mpsnh_pkg::t_scan     o_scan
);

    // slot contents, undefined until written
    logic [15:0]       r_id;
    logic [7:0]        r_hops;
    logic [15:0]       r_uplink;
    logic signed [7:0] r_rssi;

    logic                          w_valid;
    logic                          w_qual;
    logic [mpsnh_pkg::SCORE_W-1:0] w_score;
    mpsnh_pkg::t_scan              n_scan;
    mpsnh_pkg::t_scan              r_scan;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_id     <= i_nb_id;
            r_hops   <= i_nb_hops;
            r_uplink <= i_nb_uplink;
            r_rssi   <= i_nb_rssi;
        end
    end

    // slot qualification and score
    assign w_valid = int'(i_count) > CELL_IDX;
    assign w_qual  = w_valid && (r_hops < mpsnh_pkg::HOP_LIMIT) && (r_uplink != i_own_id);
    assign w_score = mpsnh_pkg::SCORE_W'(7'(r_hops[2:0]) * mpsnh_pkg::HOP_WEIGHT)
                   + mpsnh_pkg::SCORE_W'(mpsnh_pkg::link_penalty(r_rssi));

    // keep the earlier slot unless this one is strictly better
    always_comb begin
        n_scan = i_scan;
        if (w_qual && (!i_scan.found || (w_score < i_scan.score))) begin
            n_scan.found = 1'b1;
            n_scan.score = w_score;
            n_scan.id    = r_id;
            n_scan.hops  = r_hops[2:0];
            n_scan.rssi  = r_rssi;
        end
        if (w_valid && (r_id == i_dst)) begin
            n_scan.match = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
    end

    assign o_scan = r_scan;

endmodule

`default_nettype wire

@@ rtl/core/mesh_parent_select_next_hop.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   | ports                                         | handshake
// ----------+-----------------------------------------------+---------------------------
// command   | i_action, i_slot, i_valid_count, i_nb_*, i_dst | start high while busy low
// result    | o_next_hop, o_cur_parent, o_cur_hops, ...     | o_done for one cycle
// config    | psel, penable, pwrite, paddr, pwdata, prdata  | apb, pready tied high
//
// slot write and count commands give their word in the cycle after start.
// recompute and query pass a record down a row of MAX_NEIGHBORS cells, one
// cell per cycle, and give their word once the record leaves the last cell;
// busy is high while the row is walked, and no new command is taken then.
// reset is synchronous; no clearing pass, slot contents are undefined until written.
// the receiver cannot stall: each word is shown once, for one cycle.

module mesh_parent_select_next_hop #(
    parameter int MAX_NEIGHBORS = mpsnh_pkg::MAX_NEIGHBORS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    // command
    input  wire               start,
    output logic              busy,
    input  wire [1:0]         i_action,
    input  wire [3:0]         i_slot,
    input  wire [4:0]         i_valid_count,
    input  wire [15:0]        i_nb_id,
    input  wire [7:0]         i_nb_hops,
    input  wire [15:0]        i_nb_uplink,
    input  wire signed [7:0]  i_nb_rssi,
    input  wire [15:0]        i_dst,
    // result
    output logic              o_done,
    output logic [15:0]       o_next_hop,
    output logic [15:0]       o_cur_parent,
    output logic [7:0]        o_cur_hops,
    output logic signed [7:0] o_cur_parent_rssi,
    // config
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire [2:0]         paddr,
    input  wire [31:0]        pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);

    localparam logic REG_IS_ROOT = 1'b0;
    localparam logic REG_OWN_ID  = 1'b1;

    // config registers
    logic        r_is_root;
    logic [15:0] r_own_id;
    logic        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_root <= 1'b0;
            r_own_id  <= 16'd1;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_IS_ROOT: r_is_root <= pwdata[0];
                REG_OWN_ID:  r_own_id  <= pwdata[15:0];
                default:     r_is_root <= r_is_root;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_IS_ROOT: prdata = {31'd0, r_is_root};
            REG_OWN_ID:  prdata = {16'd0, r_own_id};
            default:     prdata = 32'd0;
        endcase
    end

    // command acceptance
    logic               w_accept;
    mpsnh_pkg::t_action w_action;

    assign w_action = mpsnh_pkg::t_action'(i_action);
    assign w_accept = start && !busy;

    // per-slot write enables
    logic [MAX_NEIGHBORS-1:0] w_wr;

    for (genvar g = 0; g < MAX_NEIGHBORS; g++) begin : g_wr
        assign w_wr[g] = w_accept && (w_action == mpsnh_pkg::ACT_WRITE)
                       && (int'(i_slot) == g);
    end

    // saturated valid count
    logic [CNT_W-1:0] w_count_sat;
    assign w_count_sat = (int'(i_valid_count) > MAX_NEIGHBORS)
                       ? CNT_W'(MAX_NEIGHBORS) : CNT_W'(i_valid_count);

    // control and result registers
    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_count;
    mpsnh_pkg::t_action r_action;
    logic [15:0]        r_dst;
    logic               r_done;
    logic [15:0]        r_next_hop;
    logic [15:0]        r_parent;
    logic [7:0]         r_hops;
    logic signed [7:0]  r_parent_rssi;

    // row of cells
    mpsnh_pkg::t_scan w_scan [0:MAX_NEIGHBORS];

    assign w_scan[0] = '0;

    for (genvar g = 0; g < MAX_NEIGHBORS; g++) begin : g_cell
        mpsnh_cell #(
            .CELL_IDX (g),
            .CNT_W    (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_wr_en     (w_wr[g]),
            .i_nb_id     (i_nb_id),
            .i_nb_hops   (i_nb_hops),
            .i_nb_uplink (i_nb_uplink),
            .i_nb_rssi   (i_nb_rssi),
            .i_count     (r_count),
            .i_own_id    (r_own_id),
            .i_dst       (r_dst),
            .i_scan      (w_scan[g]),
            .o_scan      (w_scan[g+1])
        );
    end

    mpsnh_pkg::t_scan w_last;
    logic             w_finish;

    assign w_last   = w_scan[MAX_NEIGHBORS];
    assign w_finish = r_busy && (r_cnt == CNT_W'(MAX_NEIGHBORS));

    // command sequencing and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_cnt         <= '0;
            r_count       <= '0;
            r_action      <= mpsnh_pkg::ACT_WRITE;
            r_done        <= 1'b0;
            r_next_hop    <= 16'd0;
            r_parent      <= 16'd0;
            r_hops        <= mpsnh_pkg::ORPHAN_HOPS;
            r_parent_rssi <= 8'sd0;
        end else begin
            r_done <= 1'b0;
            if (w_accept) begin
                r_action   <= w_action;
                r_cnt      <= '0;
                r_next_hop <= 16'd0;
                case (w_action)
                    mpsnh_pkg::ACT_WRITE: r_done <= 1'b1;
                    mpsnh_pkg::ACT_COUNT: begin
                        r_count <= w_count_sat;
                        r_done  <= 1'b1;
                    end
                    mpsnh_pkg::ACT_PARENT: r_busy <= 1'b1;
                    mpsnh_pkg::ACT_QUERY:  r_busy <= 1'b1;
                    default:               r_busy <= 1'b0;
                endcase
            end else if (w_finish) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
                case (r_action)
                    mpsnh_pkg::ACT_PARENT: begin
                        if (r_is_root) begin
                            r_parent      <= 16'd0;
                            r_hops        <= 8'd0;
                            r_parent_rssi <= 8'sd0;
                        end else if (w_last.found && (w_last.id != 16'd0)) begin
                            r_parent      <= w_last.id;
                            r_hops        <= 8'(w_last.hops) + 8'd1;
                            r_parent_rssi <= w_last.rssi;
                        end else begin
                            r_parent      <= 16'd0;
                            r_hops        <= mpsnh_pkg::ORPHAN_HOPS;
                            r_parent_rssi <= 8'sd0;
                        end
                    end
                    mpsnh_pkg::ACT_QUERY: begin
                        r_next_hop <= w_last.match ? r_dst : r_parent;
                    end
                    default: r_next_hop <= 16'd0;
                endcase
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // destination held for the whole walk
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dst <= i_dst;
        end
    end

    assign busy              = r_busy;
    assign o_done            = r_done;
    assign o_next_hop        = r_next_hop;
    assign o_cur_parent      = r_parent;
    assign o_cur_hops        = r_hops;
    assign o_cur_parent_rssi = r_parent_rssi;

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH = mpsnh_pkg::MAX_NEIGHBORS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 25;
    localparam int PRINT_CAP = 50;

    // register byte addresses
    localparam logic [2:0] ADDR_IS_ROOT = 3'd0;
    localparam logic [2:0] ADDR_NODE_ID = 3'd4;

    typedef struct packed {
        mpsnh_pkg::t_action action;
        logic [3:0]        slot;
        logic [4:0]        count;
        logic [15:0]       id;
        logic [7:0]        hops;
        logic [15:0]       uplink;
        logic signed [7:0] rssi;
        logic [15:0]       dst;
    } t_route_cmd;

    typedef struct packed {
        logic [15:0]       next_hop;
        logic [15:0]       parent;
        logic [7:0]        hops;
        logic signed [7:0] rssi;
    } t_route_res;

    // clock, reset and block inputs
    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic [1:0]        i_action = 2'd0;
    logic [3:0]        i_slot = 4'd0;
    logic [4:0]        i_valid_count = 5'd0;
    logic [15:0]       i_nb_id = 16'd0;
    logic [7:0]        i_nb_hops = 8'd0;
    logic [15:0]       i_nb_uplink = 16'd0;
    logic signed [7:0] i_nb_rssi = 8'sd0;
    logic [15:0]       i_dst = 16'd0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = 3'd0;
    logic [31:0]       pwdata = 32'd0;

    // block outputs
    logic              busy;
    logic              o_done;
    logic [15:0]       o_next_hop;
    logic [15:0]       o_cur_parent;
    logic [7:0]        o_cur_hops;
    logic signed [7:0] o_cur_parent_rssi;
    logic [31:0]       prdata;
    logic              pready;

    mesh_parent_select_next_hop dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_action          (i_action),
        .i_slot            (i_slot),
        .i_valid_count     (i_valid_count),
        .i_nb_id           (i_nb_id),
        .i_nb_hops         (i_nb_hops),
        .i_nb_uplink       (i_nb_uplink),
        .i_nb_rssi         (i_nb_rssi),
        .i_dst             (i_dst),
        .o_done            (o_done),
        .o_next_hop        (o_next_hop),
        .o_cur_parent      (o_cur_parent),
        .o_cur_hops        (o_cur_hops),
        .o_cur_parent_rssi (o_cur_parent_rssi),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // router shadow state
    logic [15:0]       nt_id     [DEPTH];
    logic [7:0]        nt_hops   [DEPTH];
    logic [15:0]       nt_uplink [DEPTH];
    logic signed [7:0] nt_rssi   [DEPTH];
    int                nt_count = 0;
    logic [15:0]       up_parent = 16'd0;
    logic [7:0]        up_hops = 8'hFF;
    logic signed [7:0] up_rssi = 8'sd0;
    logic              cfg_root = 1'b0;
    logic [15:0]       cfg_node_id = 16'd1;

    // stimulus bookkeeping
    t_route_cmd cmd_backlog[$];
    t_route_res route_due[$];
    t_route_cmd cur_cmd;
    logic       cmd_pending = 1'b0;
    int         gap_pct = 0;
    int         n_queued = 0;
    int         mismatches = 0;
    int         cycle_cnt = 0;
    logic       gen_written [DEPTH];
    logic [15:0] gen_ids    [DEPTH];
    logic [15:0] gen_node_id = 16'd1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // apply one word to the shadow router and return what the block should show
    function automatic t_route_res advance_router(t_route_cmd c);
        t_route_res r;
        logic       found;
        int         best;
        int         low_score;
        int         score;
        int         mag;
        r.next_hop = 16'd0;
        case (c.action)
            mpsnh_pkg::ACT_WRITE: begin
                nt_id[c.slot]     = c.id;
                nt_hops[c.slot]   = c.hops;
                nt_uplink[c.slot] = c.uplink;
                nt_rssi[c.slot]   = c.rssi;
            end
            mpsnh_pkg::ACT_COUNT: begin
                nt_count = (int'(c.count) > DEPTH) ? DEPTH : int'(c.count);
            end
            mpsnh_pkg::ACT_PARENT: begin
                if (cfg_root) begin
                    up_parent = 16'd0;
                    up_hops   = 8'd0;
                    up_rssi   = 8'sd0;
                end else begin
                    found     = 1'b0;
                    best      = 0;
                    low_score = 0;
                    for (int i = 0; i < nt_count; i++) begin
                        mag   = (nt_rssi[i] < 0) ? -int'(nt_rssi[i]) : int'(nt_rssi[i]);
                        score = int'(nt_hops[i]) * 10 + ((mag < 40) ? 0 : (mag - 40) / 5);
                        if (nt_hops[i] < 8 && nt_uplink[i] != cfg_node_id
                                && (!found || score < low_score)) begin
                            found     = 1'b1;
                            best      = i;
                            low_score = score;
                        end
                    end
                    if (found && nt_id[best] != 16'd0) begin
                        up_parent = nt_id[best];
                        up_hops   = nt_hops[best] + 8'd1;
                        up_rssi   = nt_rssi[best];
                    end else begin
                        up_parent = 16'd0;
                        up_hops   = 8'hFF;
                        up_rssi   = 8'sd0;
                    end
                end
            end
            default: begin
                r.next_hop = up_parent;
                for (int i = 0; i < nt_count; i++) begin
                    if (nt_id[i] == c.dst) r.next_hop = c.dst;
                end
            end
        endcase
        r.parent = up_parent;
        r.hops   = up_hops;
        r.rssi   = up_rssi;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
    endtask

    // driver: present the next word at the falling edge, hold it until taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!cmd_pending) begin
            if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
                cur_cmd = cmd_backlog.pop_front();
                i_action      <= cur_cmd.action;
                i_slot        <= cur_cmd.slot;
                i_valid_count <= cur_cmd.count;
                i_nb_id       <= cur_cmd.id;
                i_nb_hops     <= cur_cmd.hops;
                i_nb_uplink   <= cur_cmd.uplink;
                i_nb_rssi     <= cur_cmd.rssi;
                i_dst         <= cur_cmd.dst;
                start         <= 1'b1;
                cmd_pending = 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: predict on accept, check each result word against the oldest prediction
    always @(posedge i_clk) begin
        t_route_res want;
        if (i_rst_n) begin
            if (start && !busy) begin
                route_due.push_back(advance_router(cur_cmd));
                cmd_pending = 1'b0;
            end
            if (o_done) begin
                if (route_due.size() == 0) begin
                    report_mismatch("word with nothing pending", o_cur_parent, 0);
                end else begin
                    want = route_due.pop_front();
                    if (o_next_hop !== want.next_hop)
                        report_mismatch("next_hop", o_next_hop, want.next_hop);
                    if (o_cur_parent !== want.parent)
                        report_mismatch("cur_parent", o_cur_parent, want.parent);
                    if (o_cur_hops !== want.hops)
                        report_mismatch("cur_hops", o_cur_hops, want.hops);
                    if (o_cur_parent_rssi !== want.rssi)
                        report_mismatch("cur_parent_rssi", int'(o_cur_parent_rssi),
                                        int'(want.rssi));
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // random filler for fields a command does not use
    function automatic t_route_cmd noise_cmd(mpsnh_pkg::t_action a);
        t_route_cmd c;
        c.action = a;
        c.slot   = 4'($urandom);
        c.count  = 5'($urandom);
        c.id     = 16'($urandom);
        c.hops   = 8'($urandom);
        c.uplink = 16'($urandom);
        c.rssi   = 8'($urandom);
        c.dst    = 16'($urandom);
        return c;
    endfunction

    // queue a word, keeping the valid count within the written slots
    task automatic queue_cmd(input t_route_cmd c);
        int lead;
        lead = 0;
        while (lead < DEPTH && gen_written[lead]) lead++;
        if (c.action == mpsnh_pkg::ACT_COUNT && lead < DEPTH && int'(c.count) > lead)
            c.count = 5'($urandom_range(0, lead));
        if (c.action == mpsnh_pkg::ACT_WRITE) begin
            gen_written[c.slot] = 1'b1;
            gen_ids[c.slot]     = c.id;
        end
        cmd_backlog.push_back(c);
        n_queued++;
    endtask

    task automatic put_write(input logic [3:0] slot, input logic [15:0] id,
                             input logic [7:0] hops, input logic [15:0] uplink,
                             input logic signed [7:0] rssi);
        t_route_cmd c;
        c = noise_cmd(mpsnh_pkg::ACT_WRITE);
        c.slot   = slot;
        c.id     = id;
        c.hops   = hops;
        c.uplink = uplink;
        c.rssi   = rssi;
        queue_cmd(c);
    endtask

    task automatic put_count(input logic [4:0] n);
        t_route_cmd c;
        c = noise_cmd(mpsnh_pkg::ACT_COUNT);
        c.count = n;
        queue_cmd(c);
    endtask

    task automatic put_parent();
        queue_cmd(noise_cmd(mpsnh_pkg::ACT_PARENT));
    endtask

    task automatic put_query(input logic [15:0] d);
        t_route_cmd c;
        c = noise_cmd(mpsnh_pkg::ACT_QUERY);
        c.dst = d;
        queue_cmd(c);
    endtask

    // neighbor entry with plausible content: low hops, weak signals, some loops and id 0
    task automatic rand_write(input logic [3:0] slot);
        t_route_cmd c;
        int         r;
        c = noise_cmd(mpsnh_pkg::ACT_WRITE);
        c.slot = slot;
        r = $urandom_range(0, 99);
        if (r < 8) c.id = 16'd0;
        else if (r < 55) c.id = 16'($urandom_range(1, 40));
        if ($urandom_range(0, 99) < 75) c.hops = 8'($urandom_range(0, 9));
        r = $urandom_range(0, 99);
        if (r < 20) c.uplink = gen_node_id;
        else if (r < 55) c.uplink = 16'($urandom_range(0, 40));
        if ($urandom_range(0, 99) < 60) c.rssi = 8'(int'($urandom_range(0, 60)) - 90);
        queue_cmd(c);
    endtask

    task automatic rand_query();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) put_query(gen_ids[$urandom_range(0, DEPTH - 1)]);
        else if (r < 65) put_query(16'd0);
        else if (r < 80) put_query(16'($urandom_range(1, 40)));
        else put_query(16'($urandom));
    endtask

    // mostly well-formed update sequences, with queries and some noise
    task automatic random_run(input int n);
        int target;
        int r;
        int k;
        target = n_queued + n;
        while (n_queued < target) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                k = $urandom_range(1, 4);
                repeat (k) rand_write(4'($urandom));
                r = $urandom_range(0, 99);
                if (r < 30) put_count(5'd16);
                else if (r < 50) put_count(5'($urandom_range(17, 31)));
                else put_count(5'($urandom_range(0, 15)));
                put_parent();
                k = $urandom_range(0, 3);
                repeat (k) rand_query();
            end else if (r < 70) begin
                k = $urandom_range(1, 3);
                repeat (k) rand_query();
            end else if (r < 85) begin
                put_parent();
            end else begin
                queue_cmd(noise_cmd(mpsnh_pkg::t_action'($urandom_range(0, 3))));
            end
        end
    endtask

    // wait until every word has been taken and answered
    task automatic wait_quiet();
        while (cmd_backlog.size() != 0 || cmd_pending || route_due.size() != 0 || busy)
            @(posedge i_clk);
    endtask

    // register write followed by a read back
    task automatic set_reg(input logic [2:0] addr, input logic [15:0] value);
        logic [31:0] want;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_IS_ROOT) begin
            cfg_root = value[0];
            want     = {31'd0, value[0]};
        end else begin
            cfg_node_id = value;
            gen_node_id = value;
            want        = {16'd0, value};
        end
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) report_mismatch("register read back", prdata, want);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // main sequence
    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            gen_written[i] = 1'b0;
            gen_ids[i]     = 16'd0;
            nt_id[i]       = 16'd0;
            nt_hops[i]     = 8'd0;
            nt_uplink[i]   = 16'd0;
            nt_rssi[i]     = 8'sd0;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, skip rules, id 0 winner, ties, strongest and weakest rssi
        gap_pct = 0;
        put_query(16'd0);
        put_parent();
        put_write(4'd0, 16'h1234, 8'd0, 16'h0005, 8'sh80);
        put_write(4'd1, 16'hFFFF, 8'd7, 16'hFFFF, 8'sd127);
        put_write(4'd2, 16'h0000, 8'd1, 16'h0000, -8'sd40);
        put_write(4'd3, 16'h00AA, 8'd8, 16'h0000, 8'sd0);
        put_write(4'd4, 16'h5555, 8'd255, 16'h8000, -8'sd1);
        put_write(4'd5, 16'h0777, 8'd0, 16'h0001, 8'sd0);
        put_count(5'd1);
        put_parent();
        put_count(5'd6);
        put_parent();
        put_query(16'hFFFF);
        put_query(16'h0777);
        put_query(16'h4321);
        put_write(4'd2, 16'h0002, 8'd1, 16'h0000, -8'sd45);
        put_write(4'd3, 16'h0003, 8'd1, 16'h0000, -8'sd44);
        put_parent();
        put_write(4'd0, 16'h1234, 8'd1, 16'h0005, 8'sd44);
        put_parent();
        put_query(16'h4321);
        put_count(5'd0);
        put_query(16'h1234);
        put_parent();
        wait_quiet();

        // full table, highest own id, no gaps
        set_reg(ADDR_IS_ROOT, 16'd0);
        set_reg(ADDR_NODE_ID, 16'hFFFF);
        for (int s = 0; s < DEPTH; s++) rand_write(4'(s));
        random_run(330);
        wait_quiet();

        // own id zero, sparse sender
        set_reg(ADDR_NODE_ID, 16'h0000);
        gap_pct = 70;
        random_run(300);
        wait_quiet();

        // root node
        set_reg(ADDR_IS_ROOT, 16'd1);
        set_reg(ADDR_NODE_ID, 16'($urandom));
        gap_pct = 23;
        random_run(250);
        wait_quiet();

        // back to a leaf without a recompute first
        set_reg(ADDR_IS_ROOT, 16'd0);
        gap_pct = 0;
        random_run(200);
        wait_quiet();

        set_reg(ADDR_NODE_ID, 16'($urandom_range(1, 40)));
        gap_pct = 70;
        random_run(200);
        wait_quiet();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
